>>> rtl/psev_pkg.sv
package psev_pkg;

    // Operation codes carried by i_op
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Status codes reported with each result
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIV0  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       latch;   // capture the incoming transaction
        logic       push;    // push the captured value
        logic       clear;   // drop the single remaining entry
        logic       rd;      // read the second entry from the stack RAM
        logic       load;    // set up operands for the arithmetic unit
        logic       step;    // one multiply or divide iteration
        logic       commit;  // replace the two top entries with the result
        logic       report;  // register a result for the output strobe
        logic [1:0] status;  // status code that goes with the report
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_push;
        logic is_arith;
        logic is_add_sub;
        logic is_div;
        logic empty;
        logic single;
        logic full;
        logic top_zero;
        logic iter_last;
    } t_dp_stat;

endpackage

>>> rtl/postfix_stack_evaluator.sv
// Postfix (RPN) evaluator on a bounded stack of signed DATA_WIDTH-bit integers.
// A transaction is taken when start is high and busy is low; each one yields
// exactly one result, shown for a single cycle with o_strobe high. The
// receiver cannot stall, so it must capture the result in that cycle. A push,
// an unused op code or any underflow/overflow case is settled in the decode
// state; add and subtract then pass the load and write-back states, and
// multiply and divide also the calculate state of the one-bit-per-cycle
// shift-add multiplier and restoring divider. A divide by zero is flagged
// from the load state. The top entry lives in a register and the rest in a
// single-port-read RAM, so an operator reads the second operand in the
// decode state, ahead of the load state.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_push_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_top_value,
    output logic [4:0]         o_entry_count
);

    import psev_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer
    psev_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Stack, arithmetic unit and result registers
    psev_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_op),
        .i_push_value  (i_push_value),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_entry_count (o_entry_count)
    );

`ifndef SYNTH
    // An accepted transaction always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result only follows work in progress
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // A push is never issued on a full stack
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !w_stat.full)
        else $error("push issued on a full stack");

    // A result write-back needs at least two entries
    a_commit_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!w_stat.empty && !w_stat.single))
        else $error("operator result committed with fewer than two entries");
`endif

endmodule

>>> rtl/psev_ram.sv
module psev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without i_re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/psev_ctrl.sv
module psev_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  psev_pkg::t_dp_stat i_stat,
    output psev_pkg::t_dp_cmd  o_cmd
);

    import psev_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_WB     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    w_cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_stat.is_push) begin
                    w_cmd.report = 1'b1;
                    if (i_stat.full) begin
                        w_cmd.status = ST_OVER;
                    end else begin
                        w_cmd.push   = 1'b1;
                        w_cmd.status = ST_OK;
                    end
                end else if (!i_stat.is_arith) begin
                    // unused op code: report current state unchanged
                    w_cmd.report = 1'b1;
                    w_cmd.status = ST_OK;
                end else if (i_stat.empty) begin
                    w_cmd.report = 1'b1;
                    w_cmd.status = ST_UNDER;
                end else if (i_stat.single) begin
                    w_cmd.clear  = 1'b1;
                    w_cmd.report = 1'b1;
                    w_cmd.status = ST_UNDER;
                end else begin
                    w_cmd.rd = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.is_div && i_stat.top_zero) begin
                    w_cmd.report = 1'b1;
                    w_cmd.status = ST_DIV0;
                    n_state      = S_IDLE;
                end else begin
                    w_cmd.load = 1'b1;
                    n_state    = i_stat.is_add_sub ? S_WB : S_CALC;
                end
            end
            S_CALC: begin
                w_cmd.step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                w_cmd.commit = 1'b1;
                w_cmd.report = 1'b1;
                w_cmd.status = ST_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = w_cmd;

endmodule

>>> rtl/psev_dp.sv
module psev_dp #(
    parameter int STACK_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_op,
    input  logic signed [31:0]  i_push_value,
    input  psev_pkg::t_dp_cmd   i_cmd,
    output psev_pkg::t_dp_stat  o_stat,
    output logic                o_strobe,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_top_value,
    output logic [4:0]          o_entry_count
);

    import psev_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = $clog2(DATA_WIDTH);
    localparam int W  = DATA_WIDTH;
    localparam logic [IW-1:0] ITER_LAST = IW'(DATA_WIDTH - 1);

    // Transaction capture
    logic [2:0]    r_op;
    logic [W-1:0]  r_val;

    // Stack state: top entry kept in a register, the rest in RAM
    logic [W-1:0]  r_top;
    logic [W-1:0]  n_top;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Shift-add multiplier / restoring divider
    logic [W-1:0]  r_acc;
    logic [W-1:0]  n_acc;
    logic [W-1:0]  r_opa;
    logic [W-1:0]  n_opa;
    logic [W-1:0]  r_opb;
    logic [W-1:0]  n_opb;
    logic          r_neg;
    logic          n_neg;
    logic [IW-1:0] r_iter;
    logic [IW-1:0] n_iter;

    // Output registers
    logic          r_strobe;
    logic [1:0]    r_out_status;
    logic [W-1:0]  r_out_top;
    logic [CW-1:0] r_out_count;

    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic          w_we;
    logic [W-1:0]  w_second;
    logic [W-1:0]  w_mag_s;
    logic [W-1:0]  w_mag_t;
    logic [W:0]    w_rem_sh;
    logic [W:0]    w_diff;
    logic [W-1:0]  w_result;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_we     = i_cmd.push && (r_count != '0);

    psev_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cnt_m1[AW-1:0]),
        .i_wdata (r_top),
        .i_re    (i_cmd.rd),
        .i_raddr (w_cnt_m2[AW-1:0]),
        .o_rdata (w_second)
    );

    // Status toward the controller
    always_comb begin
        o_stat.is_push    = (r_op == OP_PUSH);
        o_stat.is_arith   = (r_op == OP_ADD) || (r_op == OP_SUB) ||
                            (r_op == OP_MUL) || (r_op == OP_DIV);
        o_stat.is_add_sub = (r_op == OP_ADD) || (r_op == OP_SUB);
        o_stat.is_div     = (r_op == OP_DIV);
        o_stat.empty      = (r_count == '0);
        o_stat.single     = (r_count == CW'(1));
        o_stat.full       = (r_count >= CW'(STACK_DEPTH));
        o_stat.top_zero   = (r_top == '0);
        o_stat.iter_last  = (r_iter == ITER_LAST);
    end

    // Operand magnitudes for the divider; second is the dividend
    assign w_mag_s = w_second[W-1] ? (W'(0) - w_second) : w_second;
    assign w_mag_t = r_top[W-1] ? (W'(0) - r_top) : r_top;

    // One restoring division step
    assign w_rem_sh = {r_acc, r_opa[W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_opb};

    // Final result of the operator
    always_comb begin
        unique case (r_op)
            OP_ADD:  w_result = w_second + r_top;
            OP_SUB:  w_result = w_second - r_top;
            OP_MUL:  w_result = r_acc;
            default: w_result = r_neg ? (W'(0) - r_opa) : r_opa;
        endcase
    end

    // Next values of stack and arithmetic registers
    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        n_acc   = r_acc;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_neg   = r_neg;
        n_iter  = r_iter;

        if (i_cmd.push) begin
            n_top   = r_val;
            n_count = r_count + CW'(1);
        end
        if (i_cmd.clear) begin
            n_count = '0;
        end
        if (i_cmd.commit) begin
            n_top   = w_result;
            n_count = w_cnt_m1;
        end

        if (i_cmd.load) begin
            n_acc  = '0;
            n_iter = '0;
            if (r_op == OP_MUL) begin
                n_opa = w_second;
                n_opb = r_top;
                n_neg = 1'b0;
            end else begin
                n_opa = w_mag_s;
                n_opb = w_mag_t;
                n_neg = w_second[W-1] ^ r_top[W-1];
            end
        end

        if (i_cmd.step) begin
            n_iter = r_iter + IW'(1);
            if (r_op == OP_MUL) begin
                if (r_opb[0]) begin
                    n_acc = r_acc + r_opa;
                end
                n_opa = {r_opa[W-2:0], 1'b0};
                n_opb = {1'b0, r_opb[W-1:1]};
            end else begin
                // remainder stays below the divisor, so W bits hold it
                if (!w_diff[W]) begin
                    n_acc = w_diff[W-1:0];
                    n_opa = {r_opa[W-2:0], 1'b1};
                end else begin
                    n_acc = w_rem_sh[W-1:0];
                    n_opa = {r_opa[W-2:0], 1'b0};
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.report;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_val <= W'($unsigned(i_push_value));
        end
        r_top  <= n_top;
        r_acc  <= n_acc;
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_neg  <= n_neg;
        r_iter <= n_iter;
        if (i_cmd.report) begin
            r_out_status <= i_cmd.status;
            r_out_top    <= (n_count != '0) ? n_top : '0;
            r_out_count  <= n_count;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_out_status;
    assign o_top_value   = 32'(r_out_top);
    assign o_entry_count = 5'(r_out_count);

endmodule
